// ----- hw/rtl/semt_pkg.sv -----
package semt_pkg;

  // Operation codes of an input word
  localparam logic [1:0] OpAdd    = 2'd0;
  localparam logic [1:0] OpClear  = 2'd1;
  localparam logic [1:0] OpQuery  = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  // Kind codes of a result word
  localparam logic [1:0] KindAdd   = 2'd0;
  localparam logic [1:0] KindClear = 2'd1;
  localparam logic [1:0] KindQuery = 2'd2;

  // Status codes of a result word
  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatZero = 2'd1;
  localparam logic [1:0] StatFull = 2'd2;

  // Most extents reported for one query
  localparam int unsigned MaxReports = 32;

  // Widths fixed by the word formats
  localparam int unsigned InW    = 48;
  localparam int unsigned EntW   = 49;
  localparam int unsigned TotW   = 50;
  localparam int unsigned RatioW = 17;
  localparam int unsigned CntW   = 7;

endpackage

// ----- hw/rtl/sorted_extent_merge_table.sv -----
// Sorted extent table with merge on insert.
// Input channel (in_valid_i/in_ready_o) carries one word: op, extent_start,
// extent_length, file_bytes. Output channel (out_valid_o/out_ready_i) returns
// result words; add and clear give one word, a query gives one word per
// matching extent (at most 32, last marks the final one) or one not-found word.
// Config channel (cfg_valid_i/cfg_ready_o) writes reuse_ratio; always ready.
// One word is handled at a time; in_ready_o is high only while idle.
// Steps per word:
//   add:   scan the extents, then shift later extents to open or close a slot
//   query: threshold (one shared 32x17 multiplier used twice), then a pass
//          over the extents to count matches and one to report them
//   clear: empty the table, then respond
// The memory has one registered read port, so each extent visit takes a read
// state and then an evaluate state.
// Reset empties the table (count and total to zero) and clears reuse_ratio;
// the extent memory itself is not cleared. A stalled receiver holds the
// output register, and the sequencer waits before loading the next word.
module sorted_extent_merge_table #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [47:0] extent_start_i,
  input  logic [47:0] extent_length_i,
  input  logic [47:0] file_bytes_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [1:0]  status_o,
  output logic        found_o,
  output logic [48:0] report_start_o,
  output logic [48:0] report_length_o,
  output logic        last_o,
  output logic [6:0]  entry_count_o,
  output logic [49:0] total_bytes_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = semt_pkg::EntW;
  localparam int unsigned TW = semt_pkg::TotW;

  typedef enum logic [17:0] {
    StIdle   = 18'h00001,
    StScanRd = 18'h00002,
    StScanEv = 18'h00004,
    StDecide = 18'h00008,
    StInsRd  = 18'h00010,
    StInsWr  = 18'h00020,
    StPutNew = 18'h00040,
    StMrgWr  = 18'h00080,
    StShlRd  = 18'h00100,
    StShlWr  = 18'h00200,
    StMulHi  = 18'h00400,
    StMulLo  = 18'h00800,
    StThr    = 18'h01000,
    StCntRd  = 18'h02000,
    StCntEv  = 18'h04000,
    StEmitRd = 18'h08000,
    StEmitEv = 18'h10000,
    StResp   = 18'h20000
  } state_e;

  state_e state_q, state_d;

  // extent memory
  logic [EW-1:0] start_mem [CAPACITY];
  logic [EW-1:0] len_mem   [CAPACITY];
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_start_q, rd_len_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_start, wr_len;

  // table state and config
  logic [CW-1:0] cnt_q, cnt_d;
  logic [TW-1:0] total_q, total_d;
  logic [16:0]   ratio_q;

  // work registers
  logic [47:0]   st_q, st_d, len_q, len_d, fb_q, fb_d;
  logic [EW-1:0] nend_q, nend_d, mst_q, mst_d;
  logic [TW-1:0] mend_q, mend_d, mlen_q, mlen_d, thr_q, thr_d;
  logic [CW-1:0] idx_q, idx_d, lo_q, lo_d, nmrg_q, nmrg_d, gone_q, gone_d;
  logic [CW-1:0] match_q, match_d, nrep_q, nrep_d, k_q, k_d;
  logic          lo_done_q, lo_done_d;
  logic [48:0]   phi_q, phi_d;
  logic [32:0]   plo_q, plo_d;
  logic [1:0]    res_kind_q, res_kind_d, res_stat_q, res_stat_d;

  // output register
  logic          ov_q, ov_d;
  logic [1:0]    o_kind_q, o_kind_d, o_stat_q, o_stat_d;
  logic          o_found_q, o_found_d, o_last_q, o_last_d;
  logic [EW-1:0] o_start_q, o_start_d, o_len_q, o_len_d;
  logic [6:0]    o_cnt_q, o_cnt_d;
  logic [TW-1:0] o_tot_q, o_tot_d;

  // shared multiplier and datapath terms
  logic [31:0]   mul_a;
  logic [48:0]   mul_p;
  logic [TW-1:0] rd_end, mend_fin;
  logic [CW-1:0] idx_m1, shl_dst;
  logic          slot_free, in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign slot_free   = !ov_q || out_ready_i;

  assign mul_a    = (state_q == StMulHi) ? fb_q[47:16] : {16'd0, fb_q[15:0]};
  assign mul_p    = 49'(mul_a) * 49'(ratio_q);
  assign rd_end   = TW'(rd_start_q) + TW'(rd_len_q);
  assign mend_fin = (mend_q > TW'(nend_q)) ? mend_q : TW'(nend_q);
  assign idx_m1   = idx_q - CW'(1);
  assign shl_dst  = idx_q - gone_q;

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    total_d    = total_q;
    st_d       = st_q;
    len_d      = len_q;
    fb_d       = fb_q;
    nend_d     = nend_q;
    mst_d      = mst_q;
    mend_d     = mend_q;
    mlen_d     = mlen_q;
    thr_d      = thr_q;
    idx_d      = idx_q;
    lo_d       = lo_q;
    nmrg_d     = nmrg_q;
    gone_d     = gone_q;
    match_d    = match_q;
    nrep_d     = nrep_q;
    k_d        = k_q;
    lo_done_d  = lo_done_q;
    phi_d      = phi_q;
    plo_d      = plo_q;
    res_kind_d = res_kind_q;
    res_stat_d = res_stat_q;
    rd_en      = 1'b0;
    rd_addr    = idx_q[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = idx_q[AW-1:0];
    wr_start   = rd_start_q;
    wr_len     = rd_len_q;
    ov_d       = ov_q && !out_ready_i;
    o_kind_d   = o_kind_q;
    o_stat_d   = o_stat_q;
    o_found_d  = o_found_q;
    o_start_d  = o_start_q;
    o_len_d    = o_len_q;
    o_last_d   = o_last_q;
    o_cnt_d    = o_cnt_q;
    o_tot_d    = o_tot_q;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          st_d       = extent_start_i;
          len_d      = extent_length_i;
          fb_d       = file_bytes_i;
          res_stat_d = semt_pkg::StatOk;
          unique case (op_i)
            semt_pkg::OpAdd: begin
              res_kind_d = semt_pkg::KindAdd;
              if (extent_length_i == '0) begin
                res_stat_d = semt_pkg::StatZero;
                state_d    = StResp;
              end else begin
                nend_d    = EW'(extent_start_i) + EW'(extent_length_i);
                idx_d     = '0;
                nmrg_d    = '0;
                lo_done_d = 1'b0;
                state_d   = StScanRd;
              end
            end
            semt_pkg::OpClear: begin
              res_kind_d = semt_pkg::KindClear;
              cnt_d      = '0;
              total_d    = '0;
              state_d    = StResp;
            end
            semt_pkg::OpQuery: begin
              res_kind_d = semt_pkg::KindQuery;
              if (cnt_q == '0 || file_bytes_i == '0) begin
                state_d = StResp;
              end else begin
                state_d = StMulHi;
              end
            end
            default: state_d = StIdle;
          endcase
        end
      end

      // find the first extent reaching the new start, then absorb neighbors
      StScanRd: begin
        if (idx_q == cnt_q) begin
          if (!lo_done_q) lo_d = idx_q;
          state_d = StDecide;
        end else begin
          rd_en   = 1'b1;
          state_d = StScanEv;
        end
      end
      StScanEv: begin
        if (!lo_done_q && rd_end < TW'(st_q)) begin
          idx_d   = idx_q + CW'(1);
          state_d = StScanRd;
        end else begin
          lo_done_d = 1'b1;
          if (!lo_done_q) lo_d = idx_q;
          if (rd_start_q <= nend_q) begin
            if (nmrg_q == '0) begin
              mst_d = (rd_start_q < EW'(st_q)) ? rd_start_q : EW'(st_q);
            end
            total_d = total_q - TW'(rd_len_q);
            mend_d  = rd_end;
            nmrg_d  = nmrg_q + CW'(1);
            idx_d   = idx_q + CW'(1);
            state_d = StScanRd;
          end else begin
            state_d = StDecide;
          end
        end
      end
      StDecide: begin
        if (nmrg_q == '0) begin
          if (32'(cnt_q) >= CAPACITY) begin
            res_stat_d = semt_pkg::StatFull;
            state_d    = StResp;
          end else begin
            idx_d   = cnt_q;
            state_d = StInsRd;
          end
        end else begin
          mlen_d  = mend_fin - TW'(mst_q);
          gone_d  = nmrg_q - CW'(1);
          state_d = StMrgWr;
        end
      end

      // open a slot at lo by moving later entries up one
      StInsRd: begin
        if (idx_q == lo_q) begin
          state_d = StPutNew;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_m1[AW-1:0];
          state_d = StInsWr;
        end
      end
      StInsWr: begin
        wr_en   = 1'b1;
        idx_d   = idx_m1;
        state_d = StInsRd;
      end
      StPutNew: begin
        wr_en    = 1'b1;
        wr_addr  = lo_q[AW-1:0];
        wr_start = EW'(st_q);
        wr_len   = EW'(len_q);
        cnt_d    = cnt_q + CW'(1);
        total_d  = total_q + TW'(len_q);
        state_d  = StResp;
      end

      // write the merged span, then close the gap left by absorbed entries
      StMrgWr: begin
        wr_en    = 1'b1;
        wr_addr  = lo_q[AW-1:0];
        wr_start = mst_q;
        wr_len   = EW'(mlen_q);
        total_d  = total_q + mlen_q;
        idx_d    = lo_q + nmrg_q;
        state_d  = StShlRd;
      end
      StShlRd: begin
        if (idx_q == cnt_q) begin
          cnt_d   = cnt_q - gone_q;
          state_d = StResp;
        end else begin
          rd_en   = 1'b1;
          state_d = StShlWr;
        end
      end
      StShlWr: begin
        wr_en   = 1'b1;
        wr_addr = shl_dst[AW-1:0];
        idx_d   = idx_q + CW'(1);
        state_d = StShlRd;
      end

      // threshold = (fb>>16)*ratio + ((fb&0xffff)*ratio >> 16)
      StMulHi: begin
        phi_d   = mul_p;
        state_d = StMulLo;
      end
      StMulLo: begin
        plo_d   = mul_p[32:0];
        state_d = StThr;
      end
      StThr: begin
        thr_d   = TW'(phi_q) + TW'(plo_q[32:16]);
        idx_d   = '0;
        match_d = '0;
        state_d = StCntRd;
      end

      // count matches so the final report can carry last
      StCntRd: begin
        if (idx_q == cnt_q) begin
          if (match_q == '0) begin
            state_d = StResp;
          end else begin
            nrep_d  = (32'(match_q) > semt_pkg::MaxReports) ?
                      CW'(semt_pkg::MaxReports) : match_q;
            idx_d   = '0;
            k_d     = '0;
            state_d = StEmitRd;
          end
        end else begin
          rd_en   = 1'b1;
          state_d = StCntEv;
        end
      end
      StCntEv: begin
        if (TW'(rd_len_q) >= thr_q) match_d = match_q + CW'(1);
        idx_d   = idx_q + CW'(1);
        state_d = StCntRd;
      end

      // report matching extents in table order
      StEmitRd: begin
        if (k_q == nrep_q) begin
          state_d = StIdle;
        end else begin
          rd_en   = 1'b1;
          state_d = StEmitEv;
        end
      end
      StEmitEv: begin
        if (TW'(rd_len_q) >= thr_q) begin
          if (slot_free) begin
            ov_d      = 1'b1;
            o_kind_d  = semt_pkg::KindQuery;
            o_stat_d  = semt_pkg::StatOk;
            o_found_d = 1'b1;
            o_start_d = rd_start_q;
            o_len_d   = rd_len_q;
            o_last_d  = (k_q + CW'(1) == nrep_q);
            o_cnt_d   = 7'(cnt_q);
            o_tot_d   = total_q;
            k_d       = k_q + CW'(1);
            idx_d     = idx_q + CW'(1);
            state_d   = StEmitRd;
          end
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = StEmitRd;
        end
      end

      // single result word with no extent
      StResp: begin
        if (slot_free) begin
          ov_d      = 1'b1;
          o_kind_d  = res_kind_q;
          o_stat_d  = res_stat_q;
          o_found_d = 1'b0;
          o_start_d = '0;
          o_len_d   = '0;
          o_last_d  = 1'b1;
          o_cnt_d   = 7'(cnt_q);
          o_tot_d   = total_q;
          state_d   = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_start_q <= start_mem[rd_addr];
      rd_len_q   <= len_mem[rd_addr];
    end
    if (wr_en) begin
      start_mem[wr_addr] <= wr_start;
      len_mem[wr_addr]   <= wr_len;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      total_q <= '0;
      ratio_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      ov_q    <= ov_d;
      if (cfg_valid_i && cfg_ready_o) ratio_q <= cfg_data_i;
    end
  end

  // payload and work registers
  always_ff @(posedge clk_i) begin
    st_q       <= st_d;
    len_q      <= len_d;
    fb_q       <= fb_d;
    nend_q     <= nend_d;
    mst_q      <= mst_d;
    mend_q     <= mend_d;
    mlen_q     <= mlen_d;
    thr_q      <= thr_d;
    idx_q      <= idx_d;
    lo_q       <= lo_d;
    nmrg_q     <= nmrg_d;
    gone_q     <= gone_d;
    match_q    <= match_d;
    nrep_q     <= nrep_d;
    k_q        <= k_d;
    lo_done_q  <= lo_done_d;
    phi_q      <= phi_d;
    plo_q      <= plo_d;
    res_kind_q <= res_kind_d;
    res_stat_q <= res_stat_d;
    o_kind_q   <= o_kind_d;
    o_stat_q   <= o_stat_d;
    o_found_q  <= o_found_d;
    o_start_q  <= o_start_d;
    o_len_q    <= o_len_d;
    o_last_q   <= o_last_d;
    o_cnt_q    <= o_cnt_d;
    o_tot_q    <= o_tot_d;
  end

  assign out_valid_o     = ov_q;
  assign kind_o          = o_kind_q;
  assign status_o        = o_stat_q;
  assign found_o         = o_found_q;
  assign report_start_o  = o_start_q;
  assign report_length_o = o_len_q;
  assign last_o          = o_last_q;
  assign entry_count_o   = o_cnt_q;
  assign total_bytes_o   = o_tot_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= CAPACITY)
    else $error("extent count above capacity");

  a_busy_after_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op_i != semt_pkg::OpUnused) |=> !in_ready_o)
    else $error("ready while a word is in progress");

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmitEv) |-> (k_q < nrep_q && idx_q < cnt_q))
    else $error("report beyond match count");

  a_found_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (kind_o == semt_pkg::KindQuery))
    else $error("found set on a non-query result");

endmodule

// ----- verif/extent_table_checker.sv -----
module extent_table_checker #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [16:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  op_i,
  input  logic [47:0] extent_start_i,
  input  logic [47:0] extent_length_i,
  input  logic [47:0] file_bytes_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  status_i,
  input  logic        found_i,
  input  logic [48:0] report_start_i,
  input  logic [48:0] report_length_i,
  input  logic        last_i,
  input  logic [6:0]  entry_count_i,
  input  logic [49:0] total_bytes_i,
  output int          pending_o,
  output int          fail_count_o
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic        found;
    logic [48:0] rstart;
    logic [48:0] rlength;
    logic        last;
    logic [6:0]  count;
    logic [49:0] total;
  } result_word_t;

  // predicted table contents
  logic [63:0]  ext_start [CAPACITY];
  logic [63:0]  ext_len   [CAPACITY];
  int unsigned  held;
  logic [49:0]  covered;
  logic [16:0]  ratio;

  result_word_t expected_words[$];
  int           fails;

  assign pending_o    = expected_words.size();
  assign fail_count_o = fails;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    fails++;
  endtask

  function automatic result_word_t make_word(logic [1:0] kind, logic [1:0] status,
                                             logic found, logic [63:0] st,
                                             logic [63:0] len, logic last);
    result_word_t w;
    w.kind = kind; w.status = status; w.found = found;
    w.rstart = st[48:0]; w.rlength = len[48:0]; w.last = last;
    w.count = held[6:0]; w.total = covered;
    return w;
  endfunction

  // insert with merge of touching/overlapping neighbors
  function automatic logic [1:0] insert_extent(logic [63:0] st, logic [63:0] len);
    logic [63:0] nend, mst, mend, mlen;
    int unsigned lo, hi, gone;
    if (len == 0) return semt_pkg::StatZero;
    nend = st + len;
    lo = 0;
    while (lo < held && ext_start[lo] + ext_len[lo] < st) lo++;
    hi = lo;
    while (hi < held && ext_start[hi] <= nend) hi++;
    if (lo == hi) begin
      if (held >= CAPACITY) return semt_pkg::StatFull;
      for (int i = held; i > lo; i--) begin
        ext_start[i] = ext_start[i-1];
        ext_len[i]   = ext_len[i-1];
      end
      ext_start[lo] = st & 64'h1FFFFFFFFFFFF;
      ext_len[lo]   = len & 64'h1FFFFFFFFFFFF;
      held++;
      covered = covered + len[49:0];
      return semt_pkg::StatOk;
    end
    mst  = (ext_start[lo] < st) ? ext_start[lo] : st;
    mend = ext_start[hi-1] + ext_len[hi-1];
    if (nend > mend) mend = nend;
    for (int i = lo; i < hi; i++) covered = covered - ext_len[i][49:0];
    mlen = mend - mst;
    covered = covered + mlen[49:0];
    ext_start[lo] = mst & 64'h1FFFFFFFFFFFF;
    ext_len[lo]   = mlen & 64'h1FFFFFFFFFFFF;
    gone = hi - lo - 1;
    for (int i = hi; i < held; i++) begin
      ext_start[i-gone] = ext_start[i];
      ext_len[i-gone]   = ext_len[i];
    end
    held -= gone;
    return semt_pkg::StatOk;
  endfunction

  // query: report extents at least floor(file_bytes * ratio / 2^16) long
  task automatic predict_query(logic [47:0] fb);
    logic [79:0] prod;
    logic [63:0] thr;
    int unsigned match_total, n, k;
    prod = {32'b0, fb} * {63'b0, ratio};
    thr  = prod[79:16];
    match_total = 0;
    if (held != 0 && fb != 0)
      for (int i = 0; i < held; i++) if (ext_len[i] >= thr) match_total++;
    if (match_total == 0) begin
      expected_words.push_back(make_word(semt_pkg::KindQuery, semt_pkg::StatOk, 1'b0,
                                         0, 0, 1'b1));
      return;
    end
    n = (match_total < semt_pkg::MaxReports) ? match_total : semt_pkg::MaxReports;
    k = 0;
    for (int i = 0; i < held && k < n; i++) begin
      if (ext_len[i] >= thr) begin
        expected_words.push_back(make_word(semt_pkg::KindQuery, semt_pkg::StatOk, 1'b1,
                                           ext_start[i], ext_len[i], (k + 1 == n)));
        k++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_word_t got, want;
    logic [1:0] st;
    if (!rst_ni) begin
      held = 0;
      covered = '0;
      ratio = '0;
      fails = 0;
      expected_words.delete();
    end else begin
      // compare an accepted result word with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        got = {kind_i, status_i, found_i, report_start_i, report_length_i, last_i,
               entry_count_i, total_bytes_i};
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word, kind", kind_i, 0);
        end else begin
          want = expected_words.pop_front();
          if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.found !== want.found) report_mismatch("found", got.found, want.found);
          if (got.rstart !== want.rstart)
            report_mismatch("report_start", got.rstart, want.rstart);
          if (got.rlength !== want.rlength)
            report_mismatch("report_length", got.rlength, want.rlength);
          if (got.last !== want.last) report_mismatch("last", got.last, want.last);
          if (got.count !== want.count)
            report_mismatch("entry_count", got.count, want.count);
          if (got.total !== want.total)
            report_mismatch("total_bytes", got.total, want.total);
        end
      end
      if (cfg_valid_i && cfg_ready_i) ratio = cfg_data_i;
      // predict results of an accepted input word
      if (in_valid_i && in_ready_i) begin
        case (op_i)
          semt_pkg::OpAdd: begin
            st = insert_extent({16'b0, extent_start_i}, {16'b0, extent_length_i});
            expected_words.push_back(make_word(semt_pkg::KindAdd, st, 1'b0, 0, 0, 1'b1));
          end
          semt_pkg::OpClear: begin
            held = 0;
            covered = '0;
            expected_words.push_back(make_word(semt_pkg::KindClear, semt_pkg::StatOk,
                                               1'b0, 0, 0, 1'b1));
          end
          semt_pkg::OpQuery: predict_query(file_bytes_i);
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- verif/tb_sorted_extent_merge_table.sv -----
module tb_sorted_extent_merge_table;

  localparam int unsigned CycleLimit = 1000000;
  localparam logic [1:0] OpNone = semt_pkg::OpUnused;  // ignored by the block

  logic        clk, rst_n;
  logic        cfg_valid, cfg_ready;
  logic [16:0] cfg_data;
  logic        in_valid, in_ready;
  logic [1:0]  op;
  logic [47:0] ext_start, ext_length, file_bytes;
  logic        out_valid, out_ready;
  logic [1:0]  kind, status;
  logic        found, last;
  logic [48:0] rep_start, rep_length;
  logic [6:0]  entry_count;
  logic [49:0] total_bytes;
  int          pending, fails;
  int unsigned send_idle_pct, recv_stall_pct, cycles;

  sorted_extent_merge_table i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .op_i(op),
    .extent_start_i(ext_start), .extent_length_i(ext_length), .file_bytes_i(file_bytes),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .kind_o(kind), .status_o(status),
    .found_o(found), .report_start_o(rep_start), .report_length_o(rep_length),
    .last_o(last), .entry_count_o(entry_count), .total_bytes_o(total_bytes)
  );

  extent_table_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .op_i(op),
    .extent_start_i(ext_start), .extent_length_i(ext_length), .file_bytes_i(file_bytes),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .kind_i(kind), .status_i(status),
    .found_i(found), .report_start_i(rep_start), .report_length_i(rep_length),
    .last_i(last), .entry_count_i(entry_count), .total_bytes_i(total_bytes),
    .pending_o(pending), .fail_count_o(fails)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_sorted_extent_merge_table: errors");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    return {$urandom, $urandom};
  endfunction

  // present one word and hold it until accepted
  task automatic send_word(input logic [1:0] o, input logic [47:0] st,
                           input logic [47:0] len, input logic [47:0] fb);
    in_valid <= 1'b1; op <= o; ext_start <= st; ext_length <= len; file_bytes <= fb;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // write reuse_ratio once the block has drained
  task automatic write_ratio(input logic [16:0] r);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_valid <= 1'b1; cfg_data <= r;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) send_word(OpNone, rand48(), rand48(), rand48());
    else if (r < 8) send_word(semt_pkg::OpClear, rand48(), rand48(), rand48());
    else if (r < 28) begin
      if ($urandom_range(0, 9) == 0)
        send_word(semt_pkg::OpQuery, rand48(), rand48(), rand48());
      else send_word(semt_pkg::OpQuery, rand48(), rand48(), $urandom_range(0, 8000));
    end else if (r < 31) begin
      // fill burst: disjoint extents to reach a full table
      for (int k = 0; k < 36; k++)
        send_word(semt_pkg::OpAdd, 48'd5000000 + k * 1000 + $urandom_range(0, 50),
                  $urandom_range(1, 300), rand48());
    end else if (r < 38) send_word(semt_pkg::OpAdd, rand48(), rand48(), rand48());
    else if (r < 42) send_word(semt_pkg::OpAdd, rand48(), 48'd0, rand48());
    else
      send_word(semt_pkg::OpAdd, $urandom_range(0, 40) * 100 + $urandom_range(0, 30),
                $urandom_range(1, 120), rand48());
  endtask

  initial begin
    logic [16:0] ratios [5];
    ratios = '{17'd65536, 17'h1FFFF, 17'd0, 17'd1, 17'd32768};
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_data = '0;
    in_valid = 1'b0; op = semt_pkg::OpAdd; ext_start = '0; ext_length = '0;
    file_bytes = '0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty query, zero length, extremes, merges, ignored op, clear
    send_word(semt_pkg::OpQuery, 0, 0, 48'd1000);
    send_word(semt_pkg::OpAdd, 48'd0, 48'd0, 0);
    send_word(semt_pkg::OpAdd, '1, '1, 0);
    send_word(semt_pkg::OpQuery, 0, 0, 48'd0);
    send_word(semt_pkg::OpQuery, 0, 0, '1);
    send_word(semt_pkg::OpAdd, 48'd100, 48'd50, 0);
    send_word(semt_pkg::OpAdd, 48'd200, 48'd50, 0);
    send_word(semt_pkg::OpAdd, 48'd150, 48'd50, 0);
    send_word(semt_pkg::OpAdd, 48'd90, 48'd5, 0);
    send_word(semt_pkg::OpAdd, 48'd95, 48'd5, 0);
    send_word(semt_pkg::OpAdd, 48'd0, 48'd10, 0);
    send_word(OpNone, '1, '1, '1);
    send_word(semt_pkg::OpQuery, 0, 0, 48'd1234);
    send_word(semt_pkg::OpClear, 0, 0, 0);
    send_word(semt_pkg::OpQuery, 0, 0, 48'd1234);

    // random phases, each with its own ratio; phases 1 to 3 add sender idling and receiver stalls
    for (int p = 0; p < 5; p++) begin
      write_ratio(p == 3 ? 17'($urandom_range(2, 65535)) : ratios[p]);
      case (p)
        1: begin send_idle_pct = 47; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 47; end
        3: begin send_idle_pct = 10; recv_stall_pct = 10; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 20; i++) random_word();
    end
    write_ratio(ratios[0]);
    for (int i = 0; i < 10; i++)
      send_word(semt_pkg::OpQuery, 0, 0, $urandom_range(0, 3000));

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fails == 0) $display("tb_sorted_extent_merge_table: clean");
    else $display("tb_sorted_extent_merge_table: errors");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/semt_pkg.sv
hw/rtl/sorted_extent_merge_table.sv
verif/extent_table_checker.sv
verif/tb_sorted_extent_merge_table.sv
